>>> sv/dfpa_pkg.sv
// shared types and constants of the decimal fixed-point alu
// no dependencies

`default_nettype none

package dfpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MIN      = 4'd2,
    OP_MAX      = 4'd3,
    OP_JOIN     = 4'd4,
    OP_FROM_INT = 4'd5,
    OP_FROM_Q16 = 4'd6,
    OP_MUL      = 4'd7,
    OP_TO_INT   = 4'd8
  } dfpa_op_e;

  localparam int unsigned NumStages = 5;

  localparam logic signed [15:0] FracMax  = 16'sd999;
  localparam logic signed [15:0] FracStep = 16'sd1000;
  localparam logic signed [31:0] Scale    = 32'sd1000;

  // floor(n / 1000) = (n * DivMagic) >> DivShift for any 32-bit unsigned n
  localparam logic [28:0] DivMagic = 29'd274877907;
  localparam int unsigned DivShift = 38;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } dfpa_adv_t;

endpackage

`default_nettype wire

>>> sv/dfpa_ops.sv
// first-stage logic: single-step operations and scaled multiply operands
// depends on dfpa_pkg

`default_nettype none

module dfpa_ops (
  input  logic [3:0]         op_i,
  input  logic signed [15:0] a_whole_i,
  input  logic signed [15:0] a_frac_i,
  input  logic signed [15:0] b_whole_i,
  input  logic signed [15:0] b_frac_i,
  input  logic [31:0]        q16_value_i,
  output logic signed [15:0] r_whole_o,
  output logic signed [15:0] r_frac_o,
  output logic signed [16:0] int_result_o,
  output logic               is_mul_o,
  output logic [31:0]        x_o,
  output logic [31:0]        y_o
);

  import dfpa_pkg::*;

  logic signed [15:0] add_f;
  logic signed [15:0] add_w;
  logic signed [15:0] sub_f;
  logic signed [15:0] sub_w;
  logic               a_gt_b;
  logic [25:0]        q16_scaled;
  logic signed [16:0] aw_ext;
  logic signed [31:0] x_s;
  logic signed [31:0] y_s;

  assign a_gt_b = (a_whole_i > b_whole_i) ||
                  ((a_whole_i == b_whole_i) && (a_frac_i > b_frac_i));
  assign q16_scaled = 26'(q16_value_i[15:0]) * 26'd1000;
  assign aw_ext = 17'(a_whole_i);

  assign x_s = 32'(a_whole_i) * Scale + 32'(a_frac_i);
  assign y_s = 32'(b_whole_i) * Scale + 32'(b_frac_i);
  assign x_o = x_s;
  assign y_o = y_s;
  assign is_mul_o = (op_i == OP_MUL);

  always_comb begin
    add_f = a_frac_i + b_frac_i;
    add_w = a_whole_i + b_whole_i;
    if (add_f > FracMax) begin
      add_w = add_w + 16'sd1;
      add_f = add_f - FracStep;
    end
    sub_f = a_frac_i - b_frac_i;
    sub_w = a_whole_i - b_whole_i;
    if (sub_f < 16'sd0) begin
      sub_w = sub_w - 16'sd1;
      sub_f = sub_f + FracStep;
    end
    if (sub_w < 16'sd0) begin
      sub_w = '0;
      sub_f = '0;
    end
  end

  always_comb begin
    r_whole_o    = '0;
    r_frac_o     = '0;
    int_result_o = '0;
    case (op_i)
      OP_ADD: begin
        r_whole_o = add_w;
        r_frac_o  = add_f;
      end
      OP_SUB: begin
        r_whole_o = sub_w;
        r_frac_o  = sub_f;
      end
      OP_MIN: begin
        r_whole_o = a_gt_b ? b_whole_i : a_whole_i;
        r_frac_o  = a_gt_b ? b_frac_i : a_frac_i;
      end
      OP_MAX: begin
        r_whole_o = a_gt_b ? a_whole_i : b_whole_i;
        r_frac_o  = a_gt_b ? a_frac_i : b_frac_i;
      end
      OP_JOIN: begin
        r_whole_o = a_whole_i;
        r_frac_o  = (b_whole_i > FracMax) ? FracMax : b_whole_i;
      end
      OP_FROM_INT: begin
        r_whole_o = a_whole_i;
      end
      OP_FROM_Q16: begin
        r_whole_o = q16_value_i[31:16];
        r_frac_o  = 16'(q16_scaled[25:16]);
      end
      OP_TO_INT: begin
        if (a_whole_i == 16'sd0) begin
          int_result_o = (a_frac_i != 16'sd0) ? 17'sd1 : 17'sd0;
        end else if (a_frac_i != 16'sd0) begin
          int_result_o = aw_ext + 17'sd1;
        end else begin
          int_result_o = aw_ext;
        end
      end
      default: begin
        r_whole_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/dfpa_datapath.sv
// five-stage datapath: operand stage, 32x32 product, two divide-by-1000
// stages by reciprocal multiply, remainder and result select
// depends on dfpa_pkg and dfpa_ops

`default_nettype none

module dfpa_datapath (
  input  logic                clk_i,
  input  dfpa_pkg::dfpa_adv_t adv_i,
  input  logic [3:0]          op_i,
  input  logic signed [15:0]  a_whole_i,
  input  logic signed [15:0]  a_frac_i,
  input  logic signed [15:0]  b_whole_i,
  input  logic signed [15:0]  b_frac_i,
  input  logic [31:0]         q16_value_i,
  output logic [15:0]         r_whole_o,
  output logic [15:0]         r_frac_o,
  output logic [16:0]         int_result_o
);

  import dfpa_pkg::*;

  logic signed [15:0] ops_w;
  logic signed [15:0] ops_f;
  logic signed [16:0] ops_i;
  logic               ops_mul;
  logic [31:0]        ops_x;
  logic [31:0]        ops_y;

  // result fields of non-multiply ops travel along
  logic [15:0] w1_q, w2_q, w3_q, w4_q;
  logic [15:0] f1_q, f2_q, f3_q, f4_q;
  logic [16:0] i1_q, i2_q, i3_q, i4_q;
  logic        m1_q, m2_q, m3_q, m4_q;

  logic [31:0] x_q, y_q;
  logic [31:0] p_q;
  logic [31:0] mag3;
  logic [60:0] quo3;
  logic [22:0] q_q, q4_q;
  logic        neg3_q, neg4_q;
  logic [51:0] quo4;
  logic [12:0] w_q;
  logic [22:0] wk5;
  logic [22:0] rem5;
  logic [15:0] mw5, mf5;

  logic [15:0] rw_q, rf_q;
  logic [16:0] ri_q;

  dfpa_ops u_ops (
    .op_i        (op_i),
    .a_whole_i   (a_whole_i),
    .a_frac_i    (a_frac_i),
    .b_whole_i   (b_whole_i),
    .b_frac_i    (b_frac_i),
    .q16_value_i (q16_value_i),
    .r_whole_o   (ops_w),
    .r_frac_o    (ops_f),
    .int_result_o(ops_i),
    .is_mul_o    (ops_mul),
    .x_o         (ops_x),
    .y_o         (ops_y)
  );

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      w1_q <= ops_w;
      f1_q <= ops_f;
      i1_q <= ops_i;
      m1_q <= ops_mul;
      x_q  <= ops_x;
      y_q  <= ops_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      w2_q <= w1_q;
      f2_q <= f1_q;
      i2_q <= i1_q;
      m2_q <= m1_q;
      p_q  <= 32'(x_q * y_q);
    end
  end

  assign mag3 = p_q[31] ? (32'd0 - p_q) : p_q;
  assign quo3 = 61'(mag3) * 61'(DivMagic);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      w3_q   <= w2_q;
      f3_q   <= f2_q;
      i3_q   <= i2_q;
      m3_q   <= m2_q;
      neg3_q <= p_q[31];
      q_q    <= quo3[DivShift +: 23];
    end
  end

  assign quo4 = 52'(q_q) * 52'(DivMagic);

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      w4_q   <= w3_q;
      f4_q   <= f3_q;
      i4_q   <= i3_q;
      m4_q   <= m3_q;
      neg4_q <= neg3_q;
      q4_q   <= q_q;
      w_q    <= quo4[DivShift +: 13];
    end
  end

  assign wk5  = 23'(w_q) * 23'd1000;
  assign rem5 = q4_q - wk5;
  assign mw5  = neg4_q ? (16'd0 - 16'(w_q)) : 16'(w_q);
  assign mf5  = neg4_q ? (16'd0 - 16'(rem5[9:0])) : 16'(rem5[9:0]);

  always_ff @(posedge clk_i) begin
    if (adv_i.s5) begin
      rw_q <= m4_q ? mw5 : w4_q;
      rf_q <= m4_q ? mf5 : f4_q;
      ri_q <= m4_q ? 17'd0 : i4_q;
    end
  end

  assign r_whole_o    = rw_q;
  assign r_frac_o     = rf_q;
  assign int_result_o = ri_q;

endmodule

`default_nettype wire

>>> sv/decimal_fixed_point_alu.sv
// top level of the decimal fixed-point alu: stream handshake and stage valids
// depends on dfpa_pkg and dfpa_datapath
//
// usage:
//   one transfer on the slave stream carries one operation; tuser holds the
//   opcode (add, sub, min, max, join, from int, from q16, multiply, to int),
//   tdata holds the operands. every transfer yields exactly one transfer on
//   the master stream with the whole part, thousandths part and the
//   rounded-up integer.
//   the pipeline has five register stages: operand scaling, the 32x32 product,
//   two reciprocal-multiply divides by 1000, and remainder plus result select.
//   one item per cycle is taken while the receiver takes results; every stage
//   has its own valid bit and loads when it is empty or the next stage moves,
//   so bubbles are squeezed. when the receiver stalls, the output register
//   holds its result and the stages behind it keep filling; input ready
//   drops only once all five stages are full.
//   reset clears all valid bits; the stream is empty afterwards.

`default_nettype none

module decimal_fixed_point_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation
  input  logic [3:0]  s_axis_tuser,
  // a_whole, a_frac, b_whole, b_frac, q16_value
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // r_whole, r_frac, int_result, zero fill
  output logic [55:0] m_axis_tdata
);

  import dfpa_pkg::*;

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] rdy;
  dfpa_adv_t            adv;
  logic [15:0]          r_whole;
  logic [15:0]          r_frac;
  logic [16:0]          int_result;

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign adv.s1 = rdy[0];
  assign adv.s2 = rdy[1];
  assign adv.s3 = rdy[2];
  assign adv.s4 = rdy[3];
  assign adv.s5 = rdy[4];

  dfpa_datapath u_datapath (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .op_i        (s_axis_tuser),
    .a_whole_i   (s_axis_tdata[15:0]),
    .a_frac_i    (s_axis_tdata[31:16]),
    .b_whole_i   (s_axis_tdata[47:32]),
    .b_frac_i    (s_axis_tdata[63:48]),
    .q16_value_i (s_axis_tdata[95:64]),
    .r_whole_o   (r_whole),
    .r_frac_o    (r_frac),
    .int_result_o(int_result)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = {7'd0, int_result, r_frac, r_whole};

  ast_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NumStages-1] |-> s_axis_tready
  ) else $error("input not ready although output stage is empty");

  ast_accept_fills_first: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0]
  ) else $error("accepted transfer lost at first stage");

  ast_last_stage_fills: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-2] && !vld_q[NumStages-1]) |=> vld_q[NumStages-1]
  ) else $error("item lost between stage four and output stage");

endmodule

`default_nettype wire
